// ===== hdl/occp_pkg.sv =====
// occp_pkg: widths, state codes and register indexes of the order constraint projection
// used by the top level, the serial multiplier and the serial divider; no dependencies
`timescale 1ns / 1ps

package occp_pkg;

  // serial multiplier: magnitude operand and bit-serial operand widths
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 17;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // serial divider: dividend, divisor and step count widths
  localparam int DIV_N_W   = 65;
  localparam int DIV_D_W   = 41;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // number of quotient bits for the alpha and the lambda divisions
  localparam int ALPHA_W       = 40;
  localparam int ALPHA_STEPS   = ALPHA_W;
  localparam int LAMBDA_STEPS  = DIV_N_W;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SELF_KEEP  = 2'd0,
    CFG_CROSS_KEEP = 2'd1,
    CFG_COMPLIANCE = 2'd2,
    CFG_TIME_STEP  = 2'd3
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OVL,
    ST_DT2,
    ST_PRD,
    ST_TT,
    ST_CC,
    ST_LAM,
    ST_DIV,
    ST_APL,
    ST_MA,
    ST_MB,
    ST_FIN
  } state_t;

endpackage

// ===== hdl/occp_mul.sv =====
// occp_mul: serial-parallel shift-add multiplier, one bit of the short operand per cycle
// depends on occp_pkg for operand widths
`timescale 1ns / 1ps

module occp_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [occp_pkg::MUL_A_W-1:0]  mcand,
  input  logic [occp_pkg::MUL_B_W-1:0]  mplier,
  output logic                          busy,
  output logic [occp_pkg::MUL_P_W-1:0]  prod
);

  localparam int CW = occp_pkg::MUL_CNT_W;
  localparam logic [CW-1:0] CNT_LAST = 1;

  logic [occp_pkg::MUL_P_W-1:0] sh;
  logic [occp_pkg::MUL_B_W-1:0] mp;
  logic [CW-1:0]                cnt;

  // control: step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(occp_pkg::MUL_B_W);
    end else if (busy) begin
      cnt <= cnt - CNT_LAST;
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath: add the shifted multiplicand when the current bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      sh   <= occp_pkg::MUL_P_W'(mcand);
      mp   <= mplier;
    end else if (busy) begin
      if (mp[0]) begin
        prod <= prod + sh;
      end
      sh <= sh << 1;
      mp <= mp >> 1;
    end
  end

endmodule

// ===== hdl/occp_div.sv =====
// occp_div: restoring divider, one quotient bit per cycle, dividend taken msb first
// depends on occp_pkg for operand widths
`timescale 1ns / 1ps

module occp_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [occp_pkg::DIV_N_W-1:0]    dividend,
  input  logic [occp_pkg::DIV_D_W-1:0]    divisor,
  input  logic [occp_pkg::DIV_CNT_W-1:0]  steps,
  output logic                            busy,
  output logic [occp_pkg::DIV_N_W-1:0]    quo
);

  localparam int NW = occp_pkg::DIV_N_W;
  localparam int RW = occp_pkg::DIV_D_W + 1;
  localparam int CW = occp_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] CNT_LAST = 1;

  logic [RW-1:0]                   rem;
  logic [RW-1:0]                   trial;
  logic [NW-1:0]                   dsh;
  logic [occp_pkg::DIV_D_W-1:0]    dvs;
  logic [CW-1:0]                   cnt;
  logic                            fits;

  // trial subtraction of one step
  assign trial = {rem[RW-2:0], dsh[NW-1]};
  assign fits  = (trial >= {1'b0, dvs});

  // control: step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= steps;
    end else if (busy) begin
      cnt <= cnt - CNT_LAST;
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath: partial remainder, dividend shift line and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsh <= dividend;
      dvs <= divisor;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, dvs}) : trial;
      dsh <= dsh << 1;
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule

// ===== hdl/one_sided_order_constraint_projection_top.sv =====
// one_sided_order_constraint_projection_top: sequencer and datapath of the projection step
// depends on occp_pkg, occp_mul and occp_div
`timescale 1ns / 1ps

// One item is worked on at a time, from acceptance to result. Eight passes of the serial
// multiplier take most of that time: dt squared, four keep products, the lambda product
// and two offset corrections. The 40-step alpha division runs alongside the keep products;
// the 65-step divider for the new lambda starts once it and the lambda product are done.
// A finished result waits in the output register, and the next item is accepted while it
// waits; that item then holds in its last step until the waiting result is taken. Lambda
// is kept across items and cleared by reset. Configuration writes are always taken.

module one_sided_order_constraint_projection_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] a_base_x,
  input  logic signed [31:0] a_offset,
  input  logic signed [31:0] a_ink_left,
  input  logic signed [31:0] a_ink_right,
  input  logic [15:0]        a_mobility,
  input  logic signed [31:0] b_base_x,
  input  logic signed [31:0] b_offset,
  input  logic signed [31:0] b_ink_left,
  input  logic signed [31:0] b_ink_right,
  input  logic [15:0]        b_mobility,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] a_offset_new,
  output logic signed [31:0] b_offset_new,
  output logic signed [31:0] residual,
  output logic               violated,
  output logic               skipped
);

  localparam int AW = occp_pkg::MUL_A_W;
  localparam int BW = occp_pkg::MUL_B_W;
  localparam int NW = occp_pkg::DIV_N_W;
  localparam int DW = occp_pkg::DIV_D_W;
  localparam int CW = occp_pkg::DIV_CNT_W;
  localparam logic signed [49:0] SAT_HI = 50'sh0_7FFF_FFFF;
  localparam logic signed [49:0] SAT_LO = -50'sh0_8000_0000;
  localparam logic [47:0]        LAM_MAG_MAX = 48'h8000_0000_0000;

  // saturate to the 32-bit result range
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [16:0] self_keep;
  logic [16:0] cross_keep;
  logic [31:0] compliance;
  logic [15:0] time_step;

  // control state
  occp_pkg::state_t   state;
  occp_pkg::state_t   state_next;
  logic signed [47:0] lambda;
  logic [1:0]         k;

  // item registers
  logic signed [31:0] a_off;
  logic signed [31:0] b_off;
  logic [15:0]        ma;
  logic [15:0]        mb;
  logic signed [33:0] a_left;
  logic signed [33:0] b_right;
  logic signed [32:0] wa;
  logic signed [32:0] wb;
  logic signed [34:0] ovl;
  logic signed [49:0] prd [4];
  logic signed [50:0] ta;
  logic signed [50:0] tb;
  logic signed [52:0] c;
  logic signed [47:0] new_l;
  logic signed [48:0] applied;
  logic signed [48:0] da;
  logic signed [48:0] db;

  // serial unit connections
  logic               mul_start;
  logic               mul_busy;
  logic [AW-1:0]      mul_a;
  logic [BW-1:0]      mul_b;
  logic [AW+BW-1:0]   mul_prod;
  logic               div_start;
  logic               div_busy;
  logic [NW-1:0]      div_n;
  logic [DW-1:0]      div_d;
  logic [CW-1:0]      div_steps;
  logic [NW-1:0]      div_quo;

  // derived values
  logic [15:0]        dt_eff;
  logic [16:0]        m_sum;
  logic [32:0]        wa_mag;
  logic [32:0]        wb_mag;
  logic [47:0]        lam_mag;
  logic [47:0]        app_mag;
  logic [NW-1:0]      cp;
  logic [1:0]         sel;
  logic               prd_neg;
  logic signed [49:0] pmag;
  logic signed [49:0] prd_val;
  logic signed [50:0] tmin;
  logic signed [50:0] tpos;
  logic [47:0]        qc;
  logic signed [48:0] nl49;
  logic signed [64:0] sprod;
  logic signed [64:0] sprod_rnd;
  logic signed [52:0] c_rnd;
  logic               active;
  logic               skip;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  assign dt_eff  = (time_step == '0) ? 16'd1 : time_step;
  assign m_sum   = 17'(ma) + 17'(mb);
  assign wa_mag  = wa[32] ? 33'(-wa) : 33'(wa);
  assign wb_mag  = wb[32] ? 33'(-wb) : 33'(wb);
  assign lam_mag = 48'(-lambda);
  assign app_mag = applied[48] ? 48'(-applied) : 48'(applied);
  assign active  = !c[52] && (c != '0);
  assign skip    = (m_sum == '0);
  assign cp      = active ? NW'(c[51:0]) : '0;

  // signed keep product from the multiplier magnitude
  assign prd_neg = (k == 2'd0 || k == 2'd3) ? wa[32] : wb[32];
  assign pmag    = $signed({1'b0, mul_prod[48:0]});
  assign prd_val = prd_neg ? -pmag : pmag;

  // allowed overlap and clamp of the new lambda
  assign tmin = (ta < tb) ? ta : tb;
  assign tpos = (tmin > 51'sd0) ? tmin : 51'sd0;
  assign qc   = (div_quo > NW'(LAM_MAG_MAX)) ? LAM_MAG_MAX : div_quo[47:0];
  assign nl49 = -$signed({1'b0, qc});

  // rounded offset correction, sign follows the applied change
  assign sprod     = applied[48] ? -$signed({1'b0, mul_prod[63:0]})
                                 : $signed({1'b0, mul_prod[63:0]});
  assign sprod_rnd = sprod + 65'sh8000;
  assign c_rnd     = c + 53'sh8000;

  // keep product order: self on A, cross on B, self on B, cross on A
  assign sel = (state == occp_pkg::ST_DT2) ? 2'd0 : k + 2'd1;

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      occp_pkg::ST_OVL: begin
        mul_a = AW'(dt_eff);
        mul_b = BW'(dt_eff);
      end
      occp_pkg::ST_DT2, occp_pkg::ST_PRD: begin
        mul_a = (sel == 2'd0 || sel == 2'd3) ? AW'(wa_mag) : AW'(wb_mag);
        mul_b = (sel == 2'd0 || sel == 2'd2) ? self_keep : cross_keep;
      end
      occp_pkg::ST_CC: begin
        mul_a = lam_mag;
        mul_b = m_sum;
      end
      occp_pkg::ST_APL: begin
        mul_a = app_mag;
        mul_b = BW'(ma);
      end
      occp_pkg::ST_MA: begin
        mul_a = app_mag;
        mul_b = BW'(mb);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider operands: alpha first, then the new lambda magnitude
  always_comb begin
    if (state == occp_pkg::ST_DT2) begin
      div_n     = {compliance, 8'b0, (NW - occp_pkg::ALPHA_W)'(0)};
      div_d     = DW'(mul_prod[31:0]);
      div_steps = CW'(occp_pkg::ALPHA_STEPS);
    end else begin
      div_n     = mul_prod + cp;
      div_d     = DW'(m_sum) + DW'(div_quo[occp_pkg::ALPHA_W-1:0]);
      div_steps = CW'(occp_pkg::LAMBDA_STEPS);
    end
  end

  // sequencer next state and unit starts
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      occp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = occp_pkg::ST_OVL;
        end
      end
      occp_pkg::ST_OVL: begin
        mul_start  = 1'b1;
        state_next = occp_pkg::ST_DT2;
      end
      occp_pkg::ST_DT2: begin
        if (!mul_busy) begin
          div_start  = 1'b1;
          mul_start  = 1'b1;
          state_next = occp_pkg::ST_PRD;
        end
      end
      occp_pkg::ST_PRD: begin
        if (!mul_busy) begin
          if (k == 2'd3) begin
            state_next = occp_pkg::ST_TT;
          end else begin
            mul_start = 1'b1;
          end
        end
      end
      occp_pkg::ST_TT: begin
        state_next = occp_pkg::ST_CC;
      end
      occp_pkg::ST_CC: begin
        mul_start  = 1'b1;
        state_next = occp_pkg::ST_LAM;
      end
      occp_pkg::ST_LAM: begin
        if (!mul_busy && !div_busy) begin
          div_start  = 1'b1;
          state_next = occp_pkg::ST_DIV;
        end
      end
      occp_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_next = occp_pkg::ST_APL;
        end
      end
      occp_pkg::ST_APL: begin
        mul_start  = 1'b1;
        state_next = occp_pkg::ST_MA;
      end
      occp_pkg::ST_MA: begin
        if (!mul_busy) begin
          mul_start  = 1'b1;
          state_next = occp_pkg::ST_MB;
        end
      end
      occp_pkg::ST_MB: begin
        if (!mul_busy) begin
          state_next = occp_pkg::ST_FIN;
        end
      end
      occp_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = occp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = occp_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= occp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      self_keep  <= '0;
      cross_keep <= '0;
      compliance <= '0;
      time_step  <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        occp_pkg::CFG_SELF_KEEP:  self_keep  <= cfg_data[16:0];
        occp_pkg::CFG_CROSS_KEEP: cross_keep <= cfg_data[16:0];
        occp_pkg::CFG_COMPLIANCE: compliance <= cfg_data;
        occp_pkg::CFG_TIME_STEP:  time_step  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // lambda, product counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      lambda    <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == occp_pkg::ST_DT2) begin
        k <= '0;
      end else if (state == occp_pkg::ST_PRD && !mul_busy) begin
        k <= k + 2'd1;
      end
      if (state == occp_pkg::ST_FIN && out_free) begin
        out_valid <= 1'b1;
        if (!skip) begin
          lambda <= new_l;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state)
      occp_pkg::ST_IDLE: begin
        if (in_valid) begin
          a_off   <= a_offset;
          b_off   <= b_offset;
          ma      <= a_mobility;
          mb      <= b_mobility;
          a_left  <= 34'(a_base_x) + 34'(a_offset) + 34'(a_ink_left);
          b_right <= 34'(b_base_x) + 34'(b_offset) + 34'(b_ink_right);
          wa      <= 33'(a_ink_right) - 33'(a_ink_left);
          wb      <= 33'(b_ink_right) - 33'(b_ink_left);
        end
      end
      occp_pkg::ST_OVL: begin
        ovl <= 35'(b_right) - 35'(a_left);
      end
      occp_pkg::ST_PRD: begin
        if (!mul_busy) begin
          prd[k] <= prd_val;
        end
      end
      occp_pkg::ST_TT: begin
        ta <= (51'(wa) <<< 16) - 51'((prd[0] > prd[1]) ? prd[0] : prd[1]);
        tb <= (51'(wb) <<< 16) - 51'((prd[2] > prd[3]) ? prd[2] : prd[3]);
      end
      occp_pkg::ST_CC: begin
        c <= (53'(ovl) <<< 16) - 53'(tpos);
      end
      occp_pkg::ST_DIV: begin
        if (!div_busy) begin
          new_l   <= nl49[47:0];
          applied <= nl49 - 49'(lambda);
        end
      end
      occp_pkg::ST_MA: begin
        if (!mul_busy) begin
          da <= sprod_rnd[64:16];
        end
      end
      occp_pkg::ST_MB: begin
        if (!mul_busy) begin
          db <= sprod_rnd[64:16];
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == occp_pkg::ST_FIN && out_free) begin
      a_offset_new <= (active && !skip) ? sat32(50'(a_off) - 50'(da)) : a_off;
      b_offset_new <= (active && !skip) ? sat32(50'(b_off) + 50'(db)) : b_off;
      residual     <= sat32(50'($signed(c_rnd[52:16])));
      violated     <= active;
      skipped      <= skip;
    end
  end

  occp_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .busy   (mul_busy),
    .prod   (mul_prod)
  );

  occp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .steps    (div_steps),
    .busy     (div_busy),
    .quo      (div_quo)
  );

  // lambda never goes positive
  a_lambda_nonpos: assert property (@(posedge clk) disable iff (rst)
    lambda[47] || (lambda == '0))
    else $error("lambda positive");

  // one item in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while busy");

  // a violated item never reports a negative residual
  a_violated_residual: assert property (@(posedge clk) disable iff (rst)
    (out_valid && violated) |-> !residual[31])
    else $error("violated with negative residual");

  // serial units are only started when idle
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier restarted while busy");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

// ===== sim/one_sided_order_constraint_projection_top_tb.sv =====
// one_sided_order_constraint_projection_top_tb: self-checking bench of the projection step
// depends on occp_pkg and one_sided_order_constraint_projection_top; predicts each result
`timescale 1ns / 1ps

module one_sided_order_constraint_projection_top_tb;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] a_base_x, a_offset, a_ink_left, a_ink_right;
    logic [15:0]        a_mobility;
    logic signed [31:0] b_base_x, b_offset, b_ink_left, b_ink_right;
    logic [15:0]        b_mobility;
  } mark_pair_t;

  typedef struct {
    logic signed [31:0] a_offset_new, b_offset_new, residual;
    logic               violated, skipped;
  } push_t;

  typedef struct {
    mark_pair_t pair;
    bit         known;
    push_t      want;
  } row_t;

  localparam int MAXI = 32'h7fffffff;
  localparam int MINI = 32'h80000000;
  localparam int SETTLE = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] a_base_x = '0, a_offset = '0, a_ink_left = '0, a_ink_right = '0;
  logic [15:0] a_mobility = '0;
  logic signed [31:0] b_base_x = '0, b_offset = '0, b_ink_left = '0, b_ink_right = '0;
  logic [15:0] b_mobility = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] a_offset_new, b_offset_new, residual;
  logic violated, skipped;

  one_sided_order_constraint_projection_top DUT (.*);

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of registers and lambda
  logic [16:0] keep_self = 17'd0, keep_cross = 17'd0;
  logic [31:0] softness = 32'd0;
  logic [15:0] step_dt = 16'd256;
  wide_t       lambda_acc = '0;

  push_t pending_q[$];
  int    mismatches = 0;
  bit    calm = 0;
  bit    hold_req = 0;

  function automatic logic signed [31:0] sat32(wide_t v);
    if (v > wide_t'(MAXI)) return MAXI;
    if (v < wide_t'(MINI)) return MINI;
    return v[31:0];
  endfunction

  function automatic wide_t round16(wide_t v);
    return (v + 32768) >>> 16;
  endfunction

  // one projection step, updates lambda_acc
  function automatic push_t project(mark_pair_t p);
    wide_t ovl, wa, wb, ta, tb, t, c, sk, ck, ma, mb, m;
    wide_t dt, alpha, d, cp, pr, q, newl, applied, a_new, b_new;
    push_t r;
    sk = wide_t'(keep_self);
    ck = wide_t'(keep_cross);
    ma = wide_t'(p.a_mobility);
    mb = wide_t'(p.b_mobility);
    ovl = (wide_t'(p.b_base_x) + wide_t'(p.b_offset) + wide_t'(p.b_ink_right))
        - (wide_t'(p.a_base_x) + wide_t'(p.a_offset) + wide_t'(p.a_ink_left));
    wa = wide_t'(p.a_ink_right) - wide_t'(p.a_ink_left);
    wb = wide_t'(p.b_ink_right) - wide_t'(p.b_ink_left);
    ta = wa * 65536 - ((sk * wa > ck * wb) ? sk * wa : ck * wb);
    tb = wb * 65536 - ((sk * wb > ck * wa) ? sk * wb : ck * wa);
    t = (ta < tb) ? ta : tb;
    if (t < 0) t = 0;
    c = ovl * 65536 - t;
    a_new = wide_t'(p.a_offset);
    b_new = wide_t'(p.b_offset);
    m = ma + mb;
    r.skipped = (m == 0);
    if (m != 0) begin
      dt = (step_dt != 0) ? wide_t'(step_dt) : 1;
      alpha = (wide_t'(softness) << 8) / (dt * dt);
      d = m + alpha;
      cp = (c > 0) ? c : 0;
      pr = (-lambda_acc) * m;
      q = pr / d + (pr % d + cp) / d;
      if (q > (wide_t'(1) <<< 47)) q = wide_t'(1) <<< 47;
      newl = -q;
      applied = newl - lambda_acc;
      lambda_acc = newl;
      if (c > 0) begin
        a_new = a_new - round16(ma * applied);
        b_new = b_new + round16(mb * applied);
      end
    end
    r.a_offset_new = sat32(a_new);
    r.b_offset_new = sat32(b_new);
    r.residual = sat32(round16(c));
    r.violated = (c > 0);
    return r;
  endfunction

  function automatic mark_pair_t pair_of(int abx, int ao, int ail, int air, int am,
                                         int bbx, int bo, int bil, int bir, int bm);
    mark_pair_t p;
    p.a_base_x = abx; p.a_offset = ao; p.a_ink_left = ail; p.a_ink_right = air;
    p.a_mobility = am[15:0];
    p.b_base_x = bbx; p.b_offset = bo; p.b_ink_left = bil; p.b_ink_right = bir;
    p.b_mobility = bm[15:0];
    return p;
  endfunction

  function automatic row_t row_of(mark_pair_t p, bit known, int ao, int bo, int res,
                                  bit v, bit s);
    row_t r;
    r.pair = p;
    r.known = known;
    r.want.a_offset_new = ao;
    r.want.b_offset_new = bo;
    r.want.residual = res;
    r.want.violated = v;
    r.want.skipped = s;
    return r;
  endfunction

  // well-formed pairs near each other, or full-range noise
  function automatic mark_pair_t random_pair(bit noise);
    mark_pair_t p;
    if (noise) begin
      p = pair_of($urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      p = pair_of($urandom_range(40000) - 20000, $urandom_range(8000) - 4000,
                  -$urandom_range(3000), $urandom_range(3000),
                  ($urandom_range(15) == 0) ? 0 : $urandom_range(65535),
                  $urandom_range(40000) - 20000, $urandom_range(8000) - 4000,
                  -$urandom_range(3000), $urandom_range(3000),
                  ($urandom_range(15) == 0) ? 0 : $urandom_range(65535));
    end
    return p;
  endfunction

  task automatic write_reg(occp_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      occp_pkg::CFG_SELF_KEEP:  keep_self  = val[16:0];
      occp_pkg::CFG_CROSS_KEEP: keep_cross = val[16:0];
      occp_pkg::CFG_COMPLIANCE: softness   = val;
      occp_pkg::CFG_TIME_STEP:  step_dt    = val[15:0];
      default: ;
    endcase
  endtask

  // stop offering and wait until every expected result has come
  task automatic drain;
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // offer one item, predict on acceptance
  task automatic send_pair(mark_pair_t p, bit known, push_t want);
    push_t pred;
    if (!calm) begin
      while ($urandom_range(99) < 6) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    a_base_x    <= p.a_base_x;    a_offset    <= p.a_offset;
    a_ink_left  <= p.a_ink_left;  a_ink_right <= p.a_ink_right;
    a_mobility  <= p.a_mobility;
    b_base_x    <= p.b_base_x;    b_offset    <= p.b_offset;
    b_ink_left  <= p.b_ink_left;  b_ink_right <= p.b_ink_right;
    b_mobility  <= p.b_mobility;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = project(p);
    pending_q.insert(pending_q.size(), known ? want : pred);
  endtask

  // result sink: random stalls, one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 6);
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    push_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        w = pending_q.pop_front();
        if (w.a_offset_new !== a_offset_new || w.b_offset_new !== b_offset_new ||
            w.residual !== residual || w.violated !== violated ||
            w.skipped !== skipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("bad item: exp a=%0d b=%0d r=%0d v=%0b s=%0b got a=%0d b=%0d r=%0d v=%0b s=%0b",
                     w.a_offset_new, w.b_offset_new, w.residual, w.violated, w.skipped,
                     a_offset_new, b_offset_new, residual, violated, skipped);
        end
      end
    end
  end

  // stimulus
  initial begin
    row_t  rows[$];
    push_t none;
    none = '{default: '0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset settings
    rows.insert(rows.size(), row_of(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                                    0, 0, 0, 0, 1));
    rows.insert(rows.size(), row_of(pair_of(0, MAXI, 0, 0, 0, 0, MINI, 0, 0, 0), 1,
                                    MAXI, MINI, MINI, 0, 1));
    rows.insert(rows.size(), row_of(pair_of(0, MINI, 0, 0, 0, 0, MAXI, 0, 0, 0), 1,
                                    MINI, MAXI, MAXI, 1, 1));
    rows.insert(rows.size(), row_of(pair_of(0, 0, 0, 256, 256, 0, 0, 0, 256, 256), 0,
                                    0, 0, 0, 0, 0));
    rows.insert(rows.size(), row_of(pair_of(0, 0, 0, 256, 256, -4096, 0, 0, 256, 256), 0,
                                    0, 0, 0, 0, 0));
    rows.insert(rows.size(), row_of(pair_of(MAXI, MAXI, MAXI, MAXI, 65535, MAXI, MAXI,
                                            MAXI, MAXI, 65535), 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), row_of(pair_of(MINI, MINI, MINI, MINI, 65535, MINI, MINI,
                                            MINI, MINI, 65535), 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), row_of(pair_of(MINI, MAXI, MAXI, MINI, 1, MAXI, MINI, MINI,
                                            MAXI, 0), 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), row_of(pair_of(0, 100, 500, -500, 0, 2000, -100, 300, -300,
                                            777), 0, 0, 0, 0, 0, 0));
    rows.insert(rows.size(), row_of(pair_of(5000, 0, -100, 100, 4096, 5200, 0, -100, 100,
                                            0), 0, 0, 0, 0, 0, 0));
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].known, rows[i].want);
    drain();

    // directed rows at extreme settings: keeps at and above one, zero and largest time steps
    write_reg(occp_pkg::CFG_SELF_KEEP, 32'h1ffff);
    write_reg(occp_pkg::CFG_CROSS_KEEP, 32'd65536);
    write_reg(occp_pkg::CFG_COMPLIANCE, 32'hffffffff);
    write_reg(occp_pkg::CFG_TIME_STEP, 32'd0);
    for (int i = 3; i < 10; i++) send_pair(rows[i].pair, 0, none);
    drain();
    write_reg(occp_pkg::CFG_TIME_STEP, 32'hffff);
    write_reg(occp_pkg::CFG_COMPLIANCE, 32'd1);
    write_reg(occp_pkg::CFG_SELF_KEEP, 32'd0);
    for (int i = 3; i < 10; i++) send_pair(rows[i].pair, 0, none);
    drain();

    // random phases, each with fresh settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(occp_pkg::CFG_SELF_KEEP, (ph == 1) ? 32'd65536 : $urandom_range(65536));
      write_reg(occp_pkg::CFG_CROSS_KEEP, (ph == 1) ? 32'd0 : $urandom_range(65536));
      write_reg(occp_pkg::CFG_COMPLIANCE, (ph == 0) ? 32'd0 : (ph == 5) ? 32'hffffffff
                                          : $urandom_range(1 << 20));
      write_reg(occp_pkg::CFG_TIME_STEP, (ph == 5) ? 32'd1 : $urandom_range(65535, 1));
      calm = (ph == 4);
      for (int n = 0; n < 270; n++) begin
        if (ph == 2 && n == 20) hold_req = 1;
        if (ph == 3 && n == 100) drain();
        send_pair(random_pair($urandom_range(9) == 0), 0, none);
      end
      in_valid <= 1'b0;
      calm = 0;
      drain();
    end

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("one_sided_order_constraint_projection_top: match");
    end else begin
      $display("one_sided_order_constraint_projection_top: mismatch");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #60_000_000;
    $display("one_sided_order_constraint_projection_top: mismatch");
    $finish;
  end

endmodule
